>>> hdl/sms_pkg.sv
// Shared types and constants for the stable merge sorter.
// No dependencies; imported by stable_merge_sorter_unit.
package sms_pkg;

  localparam int unsigned KEY_W = 32;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_BLK0,
    ST_BLK1,
    ST_MERGE,
    ST_OUT
  } state_e;

  // Which run head currently sits on the memory read data.
  typedef enum logic [1:0] {
    FR_NONE,
    FR_LEFT,
    FR_RIGHT
  } fresh_e;

endpackage

>>> hdl/stable_merge_sorter_unit.sv
// Stable merge sorter: stream in keys, bottom-up merge in two ping-pong RAMs, stream out.
// Depends on sms_pkg.
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+---------------------------------------
//  s_axis   | in  | tvalid / tready  | tdata = value, tlast = last
//  m_axis   | out | tvalid / tready  | tdata = value_res, tlast = last_res,
//           |     |                  | tuser = dropped
//
// Loading accepts every offered request. After the marked request the block merges:
// each pass writes one key per cycle plus ST_BLK0 and ST_BLK1 per run pair, ceil(log2 n)
// passes, bound by the single read port of the source RAM. Results leave one at a time,
// each read issued once the prior result is taken; input stays stalled from the marked
// request until the final result is taken. Reset clears control only, never the RAMs.
module stable_merge_sorter_unit #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  logic [sms_pkg::KEY_W-1:0] s_axis_tdata_i,  // [31:0] value
  input  logic                    s_axis_tlast_i,   // last
  output logic                    m_axis_tvalid_o,
  input  logic                    m_axis_tready_i,
  output logic [sms_pkg::KEY_W-1:0] m_axis_tdata_o,  // [31:0] value_res
  output logic                    m_axis_tlast_o,   // last_res
  output logic                    m_axis_tuser_o    // [0] dropped
);
  import sms_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_ITEMS);
  localparam int unsigned CNT_W  = $clog2(MAX_ITEMS + 1);
  localparam logic [CNT_W-1:0] CAP = CNT_W'(MAX_ITEMS);

  // ping-pong key RAMs
  logic [KEY_W-1:0] mem_a [MAX_ITEMS];
  logic [KEY_W-1:0] mem_b [MAX_ITEMS];
  logic [KEY_W-1:0] rd_a_q, rd_b_q, rdata;
  logic             rd_en, we_a, we_b;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [KEY_W-1:0] wr_data;

  state_e state_q, state_d;
  fresh_e fresh_q, fresh_d;
  logic [CNT_W-1:0] cnt_q, cnt_d, width_q, width_d, lo_q, lo_d;
  logic [CNT_W-1:0] mid_q, mid_d, hi_q, hi_d, i_q, i_d, j_q, j_d, k_q, k_d;
  logic [CNT_W-1:0] oidx_q, oidx_d;
  logic             ovf_q, ovf_d, src_q, src_d;
  logic [KEY_W-1:0] left_q, left_d, right_q, right_d;
  logic             pend_q, pend_d, pend_last_q, pend_last_d;
  logic             ovalid_q, ovalid_d;
  logic [KEY_W-1:0] odata_q, odata_d;
  logic             olast_q, olast_d;

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      mem_a[wr_addr] <= wr_data;
    end
    if (we_b) begin
      mem_b[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_q <= mem_a[rd_addr];
      rd_b_q <= mem_b[rd_addr];
    end
  end

  assign rdata = src_q ? rd_b_q : rd_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      fresh_q  <= FR_NONE;
      cnt_q    <= '0;
      ovf_q    <= 1'b0;
      src_q    <= 1'b0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fresh_q  <= fresh_d;
      cnt_q    <= cnt_d;
      ovf_q    <= ovf_d;
      src_q    <= src_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    width_q     <= width_d;
    lo_q        <= lo_d;
    mid_q       <= mid_d;
    hi_q        <= hi_d;
    i_q         <= i_d;
    j_q         <= j_d;
    k_q         <= k_d;
    oidx_q      <= oidx_d;
    left_q      <= left_d;
    right_q     <= right_d;
    pend_last_q <= pend_last_d;
    odata_q     <= odata_d;
    olast_q     <= olast_d;
  end

  always_comb begin
    logic [CNT_W:0]   n_new, sum_mid, sum_hi, i_nx, j_nx, k_nx, w2;
    logic [KEY_W-1:0] lv, rv, pick;
    logic             l_ok, r_ok, take_l, out_take;

    state_d     = state_q;
    fresh_d     = fresh_q;
    cnt_d       = cnt_q;
    ovf_d       = ovf_q;
    src_d       = src_q;
    width_d     = width_q;
    lo_d        = lo_q;
    mid_d       = mid_q;
    hi_d        = hi_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    oidx_d      = oidx_q;
    left_d      = left_q;
    right_d     = right_q;
    pend_d      = 1'b0;
    pend_last_d = pend_last_q;
    ovalid_d    = ovalid_q;
    odata_d     = odata_q;
    olast_d     = olast_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    we_a        = 1'b0;
    we_b        = 1'b0;
    wr_addr     = '0;
    wr_data     = s_axis_tdata_i;
    s_axis_tready_o = 1'b0;

    n_new   = {1'b0, cnt_q};
    sum_mid = {1'b0, lo_q} + {1'b0, width_q};
    sum_hi  = sum_mid + {1'b0, width_q};
    lv      = (fresh_q == FR_LEFT) ? rdata : left_q;
    rv      = (fresh_q == FR_RIGHT) ? rdata : right_q;
    l_ok    = i_q < mid_q;
    r_ok    = j_q < hi_q;
    take_l  = l_ok && (!r_ok || ($signed(lv) <= $signed(rv)));
    pick    = take_l ? lv : rv;
    i_nx    = {1'b0, i_q} + 1'b1;
    j_nx    = {1'b0, j_q} + 1'b1;
    k_nx    = {1'b0, k_q} + 1'b1;
    w2      = {width_q, 1'b0};
    out_take = ovalid_q && m_axis_tready_i;

    unique case (state_q)
      ST_LOAD: begin
        s_axis_tready_o = 1'b1;
        src_d = 1'b0;
        if (s_axis_tvalid_i) begin
          if (cnt_q < CAP) begin
            we_a    = 1'b1;
            wr_addr = cnt_q[ADDR_W-1:0];
            n_new   = {1'b0, cnt_q} + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
          cnt_d = n_new[CNT_W-1:0];
          if (s_axis_tlast_i) begin
            width_d = CNT_W'(1);
            lo_d    = '0;
            oidx_d  = '0;
            state_d = (n_new > (CNT_W+1)'(1)) ? ST_BLK0 : ST_OUT;
          end
        end
      end
      ST_BLK0: begin
        // run pair [lo, mid) and [mid, hi)
        mid_d   = (sum_mid > {1'b0, cnt_q}) ? cnt_q : sum_mid[CNT_W-1:0];
        hi_d    = (sum_hi > {1'b0, cnt_q}) ? cnt_q : sum_hi[CNT_W-1:0];
        i_d     = lo_q;
        j_d     = mid_d;
        k_d     = lo_q;
        rd_en   = 1'b1;
        rd_addr = lo_q[ADDR_W-1:0];
        state_d = ST_BLK1;
      end
      ST_BLK1: begin
        left_d  = rdata;
        if (j_q < hi_q) begin
          rd_en   = 1'b1;
          rd_addr = j_q[ADDR_W-1:0];
          fresh_d = FR_RIGHT;
        end else begin
          fresh_d = FR_NONE;
        end
        state_d = ST_MERGE;
      end
      ST_MERGE: begin
        left_d  = lv;
        right_d = rv;
        wr_addr = k_q[ADDR_W-1:0];
        wr_data = pick;
        we_a    = src_q;
        we_b    = !src_q;
        k_d     = k_nx[CNT_W-1:0];
        fresh_d = FR_NONE;
        if (take_l) begin
          i_d = i_nx[CNT_W-1:0];
          if (i_nx < {1'b0, mid_q}) begin
            rd_en   = 1'b1;
            rd_addr = i_nx[ADDR_W-1:0];
            fresh_d = FR_LEFT;
          end
        end else begin
          j_d = j_nx[CNT_W-1:0];
          if (j_nx < {1'b0, hi_q}) begin
            rd_en   = 1'b1;
            rd_addr = j_nx[ADDR_W-1:0];
            fresh_d = FR_RIGHT;
          end
        end
        if (k_nx == {1'b0, hi_q}) begin
          if (sum_hi >= {1'b0, cnt_q}) begin
            // pass complete: result now lives in the other RAM
            src_d   = !src_q;
            width_d = w2[CNT_W-1:0];
            lo_d    = '0;
            state_d = (w2 >= {1'b0, cnt_q}) ? ST_OUT : ST_BLK0;
          end else begin
            lo_d    = sum_hi[CNT_W-1:0];
            state_d = ST_BLK0;
          end
        end
      end
      ST_OUT: begin
        if (out_take) begin
          ovalid_d = 1'b0;
        end
        if (pend_q) begin
          ovalid_d = 1'b1;
          odata_d  = rdata;
          olast_d  = pend_last_q;
        end else if ((oidx_q < cnt_q) && (!ovalid_q || out_take)) begin
          rd_en       = 1'b1;
          rd_addr     = oidx_q[ADDR_W-1:0];
          pend_d      = 1'b1;
          pend_last_d = ({1'b0, oidx_q} + 1'b1) == {1'b0, cnt_q};
          oidx_d      = oidx_q + 1'b1;
        end
        if (out_take && olast_q) begin
          cnt_d   = '0;
          ovf_d   = 1'b0;
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;
  assign m_axis_tlast_o  = olast_q;
  assign m_axis_tuser_o  = ovf_q;

endmodule
